### design/ura_pkg.sv
// Shared types and constants for the ultrasonic range averager.
package ura_pkg;

  // Fixed field and register widths.
  localparam int AVG_W      = 14;
  localparam int TRIG_W     = 8;
  localparam int SETTLE_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 2'd1;

  // Register reset values and saturation limits.
  localparam logic [TRIG_W-1:0]   TRIG_RESET   = 8'd20;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd65;
  localparam logic [SETTLE_W-1:0] PHASE_MAX    = 16'hFFFF;
  localparam logic [AVG_W-1:0]    AVG_MAX      = 14'h3FFF;

  // Measurement sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_LISTEN
  } phase_t;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    logic             trigger_level;
    logic             busy_res;
    logic             done_res;
    logic [AVG_W-1:0] average_mm;
  } res_t;

endpackage

### design/ura_dist.sv
// Converts an echo pulse length in microseconds to millimeters, floor(us*17/100).
module ura_dist #(
  parameter int ECHO_COUNT_BITS = 16
) (
  input  logic [ECHO_COUNT_BITS-1:0] echo_ticks,
  output logic [ECHO_COUNT_BITS-3:0] dist_mm
);
  // us*17 is a shift and add; /100 is a multiply by a rounded-up reciprocal.
  localparam int XW = ECHO_COUNT_BITS + 5;
  localparam int SH = XW + 7;
  localparam int MW = SH - 6;
  localparam int DW = ECHO_COUNT_BITS - 2;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'd99) / 64'd100;

  logic [XW-1:0]    scaled;
  logic [XW+MW-1:0] prod;

  assign scaled  = {1'b0, echo_ticks, 4'b0000} + {5'b00000, echo_ticks};
  assign prod    = {{MW{1'b0}}, scaled} * {{XW{1'b0}}, RECIP[MW-1:0]};
  assign dist_mm = prod[SH +: DW];

endmodule

### design/ura_ctrl.sv
// Measurement sequencer: trigger timing, echo pulse timing, round sum and average.
module ura_ctrl #(
  parameter int ROUNDS_LOG2     = 3,
  parameter int ECHO_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ura_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           acc,
  input  logic                           echo_level,
  input  logic                           start_req,
  input  logic [ECHO_COUNT_BITS-3:0]     dist_mm,
  output logic [ECHO_COUNT_BITS-1:0]     echo_ticks_r,
  output ura_pkg::res_t                  res
);
  import ura_pkg::*;

  localparam int DW = ECHO_COUNT_BITS - 2;
  localparam int SW = DW + ROUNDS_LOG2;
  localparam int RW = (ROUNDS_LOG2 > 0) ? ROUNDS_LOG2 : 1;
  localparam logic [RW-1:0] LAST_ROUND = RW'((1 << ROUNDS_LOG2) - 1);

  logic [TRIG_W-1:0]          trig_cfg_r;
  logic [SETTLE_W-1:0]        settle_cfg_r;
  phase_t                     phase_r, phase_nxt;
  logic [SETTLE_W-1:0]        ph_ticks_r, ph_ticks_nxt;
  logic [ECHO_COUNT_BITS-1:0] echo_ticks_nxt;
  logic                       echo_prev_r;
  logic                       seen_end_r, seen_end_nxt;
  logic [RW-1:0]              round_r, round_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  logic [AVG_W-1:0]           avg_r, avg_nxt;
  logic                       done;

  logic [TRIG_W-1:0]   trig_len;
  logic                trig_over;
  logic [SETTLE_W-1:0] listen_ticks;
  logic                seen_set;
  logic                round_end;
  logic                last_round;
  logic [SW-1:0]       sum_add;
  logic [31:0]         avg_ext;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_cfg_r   <= TRIG_RESET;
      settle_cfg_r <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_TICKS: trig_cfg_r   <= cfg_wdata[TRIG_W-1:0];
        CFG_SETTLE_TICKS:  settle_cfg_r <= cfg_wdata[SETTLE_W-1:0];
        default:           ;
      endcase
    end
  end

  // Shared decisions of the current tick.
  assign trig_len     = (trig_cfg_r == '0) ? TRIG_W'(1) : trig_cfg_r;
  assign trig_over    = ph_ticks_r >= {{(SETTLE_W-TRIG_W){1'b0}}, trig_len};
  assign listen_ticks = (ph_ticks_r == PHASE_MAX) ? ph_ticks_r : ph_ticks_r + 1'b1;
  assign seen_set     = !seen_end_r && !echo_level && echo_prev_r && (echo_ticks_r != '0);
  assign round_end    = (phase_r == PH_LISTEN) && (listen_ticks >= settle_cfg_r) &&
                        (seen_end_r || seen_set);
  assign last_round   = (round_r == LAST_ROUND);
  assign sum_add      = sum_r + {{ROUNDS_LOG2{1'b0}}, dist_mm};
  assign avg_ext      = 32'(sum_add >> ROUNDS_LOG2);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) phase_nxt = PH_TRIG;
      end
      PH_TRIG: begin
        if (trig_over) phase_nxt = PH_LISTEN;
      end
      PH_LISTEN: begin
        if (round_end) phase_nxt = last_round ? PH_IDLE : PH_TRIG;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Counters, echo timing and the running sum.
  always_comb begin
    ph_ticks_nxt   = ph_ticks_r;
    echo_ticks_nxt = echo_ticks_r;
    seen_end_nxt   = seen_end_r;
    round_nxt      = round_r;
    sum_nxt        = sum_r;
    avg_nxt        = avg_r;
    done           = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (start_req) begin
        round_nxt      = '0;
        sum_nxt        = '0;
        ph_ticks_nxt   = SETTLE_W'(1);
        echo_ticks_nxt = '0;
        seen_end_nxt   = 1'b0;
      end
    end else begin
      // Only the first pulse that rises inside the round is timed.
      if (!seen_end_r) begin
        if (echo_level && !echo_prev_r) begin
          echo_ticks_nxt = ECHO_COUNT_BITS'(1);
        end else if (echo_level && echo_prev_r) begin
          if ((echo_ticks_r != '0) && !(&echo_ticks_r)) echo_ticks_nxt = echo_ticks_r + 1'b1;
        end else if (seen_set) begin
          seen_end_nxt = 1'b1;
        end
      end
      if (phase_r == PH_TRIG) begin
        ph_ticks_nxt = trig_over ? '0 : ph_ticks_r + 1'b1;
      end else begin
        ph_ticks_nxt = listen_ticks;
        if (round_end) begin
          sum_nxt   = sum_add;
          round_nxt = round_r + 1'b1;
          if (last_round) begin
            avg_nxt      = (avg_ext > 32'(AVG_MAX)) ? AVG_MAX : avg_ext[AVG_W-1:0];
            ph_ticks_nxt = '0;
            done         = 1'b1;
          end else begin
            ph_ticks_nxt   = SETTLE_W'(1);
            echo_ticks_nxt = '0;
            seen_end_nxt   = 1'b0;
          end
        end
      end
    end
  end

  // Result fields follow the state after the tick.
  always_comb begin
    res.trigger_level = (phase_nxt == PH_TRIG);
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done;
    res.average_mm    = avg_nxt;
  end

  // State advances once per transferred tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ph_ticks_r   <= '0;
      echo_ticks_r <= '0;
      echo_prev_r  <= 1'b0;
      seen_end_r   <= 1'b0;
      round_r      <= '0;
      sum_r        <= '0;
      avg_r        <= '0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      ph_ticks_r   <= ph_ticks_nxt;
      echo_ticks_r <= echo_ticks_nxt;
      echo_prev_r  <= echo_level;
      seen_end_r   <= seen_end_nxt;
      round_r      <= round_nxt;
      sum_r        <= sum_nxt;
      avg_r        <= avg_nxt;
    end
  end

  // A finished pulse always has a nonzero length.
  a_seen_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    seen_end_r |-> (echo_ticks_r != '0))
    else $error("echo end seen with zero pulse length");

  // The trigger phase always counts from one.
  a_trig_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRIG) |-> (ph_ticks_r != '0))
    else $error("trigger phase with zero tick count");

  // Without a transfer the sequencer does not move.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(phase_r) && $stable(sum_r) && $stable(avg_r))
    else $error("sequencer state changed without a transfer");

  // Idle without a start request stays idle.
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (phase_r == PH_IDLE) && !start_req) |=> (phase_r == PH_IDLE))
    else $error("left idle without a start request");

endmodule

### design/ura_out.sv
// Result register stage with transfer handshake toward both sides.
module ura_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          acc,
  input  ura_pkg::res_t res,
  output logic          out_valid,
  input  logic          out_ready,
  output ura_pkg::res_t out_res
);
  import ura_pkg::*;

  logic valid_r;
  res_t res_r;

  // A new tick is taken whenever the held result leaves or none is held.
  assign in_ready  = !valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

endmodule

### design/ultrasonic_range_averager_top.sv
// A tick's result is registered at the same edge that transfers the tick.
// Throughput: one tick per clock while out_ready is high or no result is held; the
// result register is reloaded in the same cycle that its held result is transferred out.
// The distance multiplier is combinational on the sequencer's registered pulse length.
// Reset (synchronous, active low) clears the sequencer to idle, the average to zero,
// the output valid flag, and loads trigger_ticks 20 and settle_ticks 65.
module ultrasonic_range_averager_top #(
  parameter int ROUNDS_LOG2     = 3,
  parameter int ECHO_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ura_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_echo_level,
  input  logic                           in_start_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_trigger_level,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [ura_pkg::AVG_W-1:0]      out_average_mm
);
  import ura_pkg::*;

  logic                       acc;
  logic [ECHO_COUNT_BITS-1:0] echo_ticks;
  logic [ECHO_COUNT_BITS-3:0] dist_mm;
  res_t                       res;
  res_t                       out_res;

  // Pulse length to distance.
  ura_dist #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_dist (
    .echo_ticks(echo_ticks),
    .dist_mm   (dist_mm)
  );

  // Sequencer.
  ura_ctrl #(
    .ROUNDS_LOG2    (ROUNDS_LOG2),
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .echo_level  (in_echo_level),
    .start_req   (in_start_req),
    .dist_mm     (dist_mm),
    .echo_ticks_r(echo_ticks),
    .res         (res)
  );

  // Result register.
  ura_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .acc      (acc),
    .res      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_trigger_level = out_res.trigger_level;
  assign out_busy_res      = out_res.busy_res;
  assign out_done_res      = out_res.done_res;
  assign out_average_mm    = out_res.average_mm;

endmodule
